### hw/rtl/lctr_pkg.sv
// Shared types and codes for the line cache tag and replacement engine.
package lctr_pkg;

  localparam logic [1:0] MODE_REQUEST = 2'd0;
  localparam logic [1:0] MODE_FRAME   = 2'd1;
  localparam logic [1:0] MODE_EVICT   = 2'd2;
  localparam logic [1:0] MODE_CLEAR   = 2'd3;

  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_INSERT  = 3'd1;
  localparam logic [2:0] ST_OUTSIDE = 3'd2;
  localparam logic [2:0] ST_NONE    = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;

  localparam int unsigned MB_W = 7;

  typedef struct packed {
    logic        vld;
    logic [15:0] file;
    logic [30:0] line;
    logic [7:0]  pers;
    logic [31:0] frame;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic       accept;
    logic       hit_start;
    logic       vic_start;
    logic       scan_run;
    logic       clr_start;
    logic       clr_run;
    logic       wr_upd;
    logic       wr_evict;
    logic       wr_ins;
    logic       frame_inc;
    logic       clr_count;
    logic       st_set;
    logic [2:0] st_code;
    logic       load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       scan_done;
    logic       sweep_last;
    logic       found;
    logic       best_vld;
    logic       over_cap;
    logic       outside;
    logic       no_free;
    logic       out_busy;
    logic [1:0] mode;
  } stat_t;

endpackage

### hw/rtl/lctr_ctrl.sv
// Sequencer for request, frame, evict and clear operations.
module lctr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     in_mode,
  input  lctr_pkg::stat_t st,
  output lctr_pkg::cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_INIT  = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_HSCAN = 10'b0000000100,
    S_DEC   = 10'b0000001000,
    S_VSCAN = 10'b0000010000,
    S_EVICT = 10'b0000100000,
    S_INS   = 10'b0001000000,
    S_UPD   = 10'b0010000000,
    S_CLR   = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_INIT: begin
        cmd.clr_run = 1'b1;
        if (st.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          cmd.st_set = 1'b1;
          cmd.st_code = lctr_pkg::ST_DONE;
          case (in_mode)
            lctr_pkg::MODE_REQUEST: begin
              cmd.hit_start = 1'b1;
              state_nxt = S_HSCAN;
            end
            lctr_pkg::MODE_FRAME: begin
              cmd.frame_inc = 1'b1;
              state_nxt = S_DONE;
            end
            lctr_pkg::MODE_EVICT: begin
              cmd.vic_start = 1'b1;
              state_nxt = S_VSCAN;
            end
            default: begin
              cmd.clr_count = 1'b1;
              cmd.clr_start = 1'b1;
              state_nxt = S_CLR;
            end
          endcase
        end
      end
      S_HSCAN: begin
        cmd.scan_run = 1'b1;
        if (st.scan_done) begin
          state_nxt = st.found ? S_UPD : S_DEC;
        end
      end
      S_DEC: begin
        if (st.over_cap) begin
          cmd.vic_start = 1'b1;
          state_nxt = S_VSCAN;
        end else if (st.outside) begin
          cmd.st_set = 1'b1;
          cmd.st_code = lctr_pkg::ST_OUTSIDE;
          state_nxt = S_DONE;
        end else if (st.no_free) begin
          cmd.st_set = 1'b1;
          cmd.st_code = lctr_pkg::ST_NONE;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_INS;
        end
      end
      S_VSCAN: begin
        cmd.scan_run = 1'b1;
        if (st.scan_done) begin
          if (st.best_vld) begin
            state_nxt = S_EVICT;
          end else begin
            cmd.st_set = 1'b1;
            cmd.st_code = lctr_pkg::ST_NONE;
            state_nxt = S_DONE;
          end
        end
      end
      S_EVICT: begin
        cmd.wr_evict = 1'b1;
        state_nxt = (st.mode == lctr_pkg::MODE_EVICT) ? S_DONE : S_DEC;
      end
      S_INS: begin
        cmd.wr_ins = 1'b1;
        cmd.st_set = 1'b1;
        cmd.st_code = lctr_pkg::ST_INSERT;
        state_nxt = S_DONE;
      end
      S_UPD: begin
        cmd.wr_upd = 1'b1;
        cmd.st_set = 1'b1;
        cmd.st_code = lctr_pkg::ST_HIT;
        state_nxt = S_DONE;
      end
      S_CLR: begin
        cmd.clr_run = 1'b1;
        if (st.sweep_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/lctr_dp.sv
// Tag memory, scan engine, counters and result register.
module lctr_dp #(
  parameter int unsigned ENTRIES = 2048,
  parameter int unsigned LINES_PER_MEGABYTE = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lctr_pkg::cmd_t             cmd,
  output lctr_pkg::stat_t            st,
  input  logic [lctr_pkg::MB_W-1:0]  cache_mb,
  input  logic [1:0]                 in_mode,
  input  logic [15:0]                in_file,
  input  logic [30:0]                in_line,
  input  logic [30:0]                in_flen,
  input  logic [7:0]                 in_pers,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 out_status,
  output logic [10:0]                out_slot,
  output logic [11:0]                out_evicted,
  output logic [11:0]                out_lines
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned PW = lctr_pkg::MB_W + 9;
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);

  lctr_pkg::entry_t mem [ENTRIES];
  lctr_pkg::entry_t rd_r;
  lctr_pkg::entry_t wdata;
  logic [IW-1:0]    waddr;
  logic             we;

  logic [CW-1:0] cnt_r;
  logic          rd_vld_r;
  logic [IW-1:0] rd_idx_r;
  logic          kind_hit_r;

  logic [1:0]  mode_r;
  logic [15:0] file_r;
  logic [30:0] line_r;
  logic [30:0] flen_r;
  logic [7:0]  pers_r;

  logic          found_r;
  logic [IW-1:0] found_idx_r;
  logic [7:0]    found_pers_r;
  logic [CW-1:0] free_r;
  logic          best_vld_r;
  logic [IW-1:0] best_idx_r;
  logic [7:0]    best_pers_r;
  logic [31:0]   best_frame_r;

  logic [CW-1:0] vcount_r;
  logic [31:0]   frame_r;
  logic [2:0]    res_status_r;
  logic [IW-1:0] res_slot_r;
  logic [CW-1:0] res_evict_r;

  logic          out_valid_r;
  logic [2:0]    out_status_r;
  logic [10:0]   out_slot_r;
  logic [11:0]   out_evicted_r;
  logic [11:0]   out_lines_r;

  logic [lctr_pkg::MB_W-1:0] mb_eff;
  logic [PW-1:0]             cap_raw;
  logic [CW-1:0]             cap;
  logic                      better;

  // capacity in lines, zero megabytes counts as one
  assign mb_eff  = (cache_mb == '0) ? lctr_pkg::MB_W'(1) : cache_mb;
  assign cap_raw = PW'(mb_eff) * PW'(LINES_PER_MEGABYTE);
  assign cap     = ({1'b0, cap_raw} > (PW + 1)'(ENTRIES)) ? FULL : CW'(cap_raw);

  assign better = rd_r.vld && (!best_vld_r || (rd_r.pers < best_pers_r) ||
                  ((rd_r.pers == best_pers_r) && (rd_r.frame < best_frame_r)));

  always_comb begin
    we = 1'b0;
    waddr = cnt_r[IW-1:0];
    wdata = '0;
    if (cmd.clr_run) begin
      we = 1'b1;
    end else if (cmd.wr_evict) begin
      we = 1'b1;
      waddr = best_idx_r;
    end else if (cmd.wr_ins) begin
      we = 1'b1;
      waddr = free_r[IW-1:0];
      wdata = '{vld: 1'b1, file: file_r, line: line_r, pers: pers_r, frame: frame_r};
    end else if (cmd.wr_upd) begin
      we = 1'b1;
      waddr = found_idx_r;
      wdata = '{vld: 1'b1, file: file_r, line: line_r,
                pers: (pers_r > found_pers_r) ? pers_r : found_pers_r, frame: frame_r};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[cnt_r[IW-1:0]];
  end

  // scan and sweep control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_run && (cnt_r != FULL);
      if (cmd.hit_start || cmd.vic_start || cmd.clr_start) begin
        cnt_r <= '0;
      end else if ((cmd.scan_run && (cnt_r != FULL)) || cmd.clr_run) begin
        cnt_r <= (cmd.clr_run && (cnt_r == FULL - 1'b1)) ? '0 : cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r[IW-1:0];
    if (cmd.accept) begin
      mode_r <= in_mode;
      file_r <= in_file;
      line_r <= in_line;
      flen_r <= in_flen;
      pers_r <= in_pers;
    end
    if (cmd.hit_start) begin
      kind_hit_r <= 1'b1;
      found_r <= 1'b0;
      free_r <= FULL;
    end else if (cmd.vic_start) begin
      kind_hit_r <= 1'b0;
      best_vld_r <= 1'b0;
    end else if (rd_vld_r && kind_hit_r) begin
      if (rd_r.vld && !found_r && (rd_r.file == file_r) && (rd_r.line == line_r)) begin
        found_r <= 1'b1;
        found_idx_r <= rd_idx_r;
        found_pers_r <= rd_r.pers;
      end
      if (!rd_r.vld && (free_r == FULL)) begin
        free_r <= {1'b0, rd_idx_r};
      end
    end else if (rd_vld_r && better) begin
      best_vld_r <= 1'b1;
      best_idx_r <= rd_idx_r;
      best_pers_r <= rd_r.pers;
      best_frame_r <= rd_r.frame;
    end else if (cmd.wr_evict && ({1'b0, best_idx_r} < free_r)) begin
      free_r <= {1'b0, best_idx_r};
    end
    // clear-all latches the count when the command is taken
    if (cmd.accept) begin
      res_slot_r <= '0;
      res_evict_r <= cmd.clr_count ? vcount_r : '0;
    end else if (cmd.wr_evict) begin
      res_evict_r <= res_evict_r + 1'b1;
    end else if (cmd.wr_ins) begin
      res_slot_r <= free_r[IW-1:0];
    end else if (cmd.wr_upd) begin
      res_slot_r <= found_idx_r;
    end
    if (cmd.st_set) begin
      res_status_r <= cmd.st_code;
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_slot_r <= 11'(res_slot_r);
      out_evicted_r <= 12'(res_evict_r);
      out_lines_r <= 12'(vcount_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
      frame_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.frame_inc) begin
        frame_r <= frame_r + 32'd1;
      end
      if (cmd.clr_run) begin
        vcount_r <= '0;
      end else if (cmd.wr_evict) begin
        vcount_r <= vcount_r - 1'b1;
      end else if (cmd.wr_ins) begin
        vcount_r <= vcount_r + 1'b1;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign st.scan_done  = (cnt_r == FULL) && !rd_vld_r;
  assign st.sweep_last = (cnt_r == FULL - 1'b1);
  assign st.found      = found_r;
  assign st.best_vld   = best_vld_r;
  assign st.over_cap   = ({1'b0, vcount_r} + 1'b1) > {1'b0, cap};
  assign st.outside    = (flen_r != '0) && (line_r >= flen_r);
  assign st.no_free    = (free_r == FULL);
  assign st.out_busy   = out_valid_r && !out_ready;
  assign st.mode       = mode_r;

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_slot    = out_slot_r;
  assign out_evicted = out_evicted_r;
  assign out_lines   = out_lines_r;

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr_run, cmd.wr_evict, cmd.wr_ins, cmd.wr_upd}))
    else $error("more than one tag write in a cycle");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vcount_r <= FULL)
    else $error("line count above entries");
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("result not presented after load");
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid_r && !out_ready))
    else $error("result overwritten while stalled");

endmodule

### hw/rtl/line_cache_tag_replacement.sv
// Top level of the line cache tag and replacement engine.
//
// Input word (in_*): in_tuser carries the mode (request, frame tick, evict
// one, clear all); in_tdata carries file id, line index, file length and
// persistence. One result word (out_*) follows every input word: status,
// slot, number of lines evicted and lines in use afterwards.
// cfg_* writes the cache size in megabytes; it is always ready and must only
// be written while no word is in flight.
//
// Sequence: a request scans the whole tag memory once, then each eviction
// costs another full scan plus one tag write; a hit update or insert adds
// one tag write. Clear all sweeps the whole tag memory; a frame tick only
// advances the frame counter.
// One word is worked on at a time; input is taken again once the result is
// in the output register, even if the sink has not taken it yet.
// After reset the block sweeps the whole tag memory with
// in_tready low. A stalled sink holds the result and, once the next word is
// done, holds the engine until the output register frees up.
module line_cache_tag_replacement #(
  parameter int unsigned ENTRIES = 2048,
  parameter int unsigned LINES_PER_MEGABYTE = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // mode
  input  logic [87:0] in_tdata,   // file_id, line_index, file_length_lines, persistence
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // status, slot, evicted_count, lines_in_use
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data    // cache_megabytes
);

  lctr_pkg::cmd_t  cmd;
  lctr_pkg::stat_t st;

  logic [lctr_pkg::MB_W-1:0] cache_mb_r;
  logic [2:0]  o_status;
  logic [10:0] o_slot;
  logic [11:0] o_evicted;
  logic [11:0] o_lines;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_mb_r <= 7'd64;
    end else if (cfg_valid) begin
      cache_mb_r <= cfg_data;
    end
  end

  lctr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_mode  (in_tuser),
    .st       (st),
    .cmd      (cmd)
  );

  lctr_dp #(
    .ENTRIES            (ENTRIES),
    .LINES_PER_MEGABYTE (LINES_PER_MEGABYTE)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .st          (st),
    .cache_mb    (cache_mb_r),
    .in_mode     (in_tuser),
    .in_file     (in_tdata[15:0]),
    .in_line     (in_tdata[46:16]),
    .in_flen     (in_tdata[77:47]),
    .in_pers     (in_tdata[85:78]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_status  (o_status),
    .out_slot    (o_slot),
    .out_evicted (o_evicted),
    .out_lines   (o_lines)
  );

  assign out_tdata = {2'b00, o_lines, o_evicted, o_slot, o_status};

endmodule

### verif/tb_line_cache_tag_replacement.sv
// Testbench for the line cache tag and replacement engine.
`timescale 1ns / 100ps

module tb_line_cache_tag_replacement;

  localparam int unsigned NUM_SLOTS = 2048;
  localparam int unsigned LINES_PER_MB = 16;
  localparam int unsigned STALL_LIMIT = 2000000;

  typedef struct {
    logic [1:0]  mode;
    logic [15:0] file_id;
    logic [30:0] line_index;
    logic [30:0] file_len;
    logic [7:0]  pers;
  } lookup_t;

  typedef struct {
    logic [2:0]  status;
    logic [10:0] slot;
    logic [11:0] evicted;
    logic [11:0] in_use;
  } outcome_t;

  // Mirror of the tag store plus the queue of outcomes still owed by the block.
  class cache_scoreboard;
    bit          valid_q[NUM_SLOTS];
    logic [15:0] tag_file[NUM_SLOTS];
    logic [30:0] tag_line[NUM_SLOTS];
    logic [7:0]  tag_pers[NUM_SLOTS];
    logic [31:0] tag_frame[NUM_SLOTS];
    logic [31:0] frame_now;
    int unsigned used;
    logic [6:0]  megabytes;
    outcome_t    owed[$];
    int          errors;

    function new();
      foreach (valid_q[i]) valid_q[i] = 0;
      frame_now = 0;
      used = 0;
      megabytes = 7'd64;
      errors = 0;
    endfunction

    function int unsigned capacity();
      int unsigned mb;
      mb = (megabytes == 0) ? 1 : megabytes;
      return (mb * LINES_PER_MB > NUM_SLOTS) ? NUM_SLOTS : mb * LINES_PER_MB;
    endfunction

    // Least persistence, then oldest frame, then lowest slot.
    function bit drop_victim();
      int best;
      best = -1;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!valid_q[i]) continue;
        if (best < 0 || tag_pers[i] < tag_pers[best] ||
            (tag_pers[i] == tag_pers[best] && tag_frame[i] < tag_frame[best]))
          best = i;
      end
      if (best < 0) return 0;
      valid_q[best] = 0;
      used--;
      return 1;
    endfunction

    function void note_input(lookup_t r);
      outcome_t o;
      int hit_at;
      int free_at;
      o.status = lctr_pkg::ST_DONE;
      o.slot = '0;
      o.evicted = '0;
      hit_at = -1;
      free_at = -1;
      case (r.mode)
        lctr_pkg::MODE_REQUEST: begin
          for (int i = 0; i < NUM_SLOTS; i++)
            if (valid_q[i] && tag_file[i] == r.file_id && tag_line[i] == r.line_index) begin
              hit_at = i;
              break;
            end
          if (hit_at >= 0) begin
            tag_frame[hit_at] = frame_now;
            if (r.pers > tag_pers[hit_at]) tag_pers[hit_at] = r.pers;
            o.status = lctr_pkg::ST_HIT;
            o.slot = 11'(hit_at);
          end else begin
            o.status = lctr_pkg::ST_INSERT;
            while (used + 1 > capacity()) begin
              if (!drop_victim()) begin
                o.status = lctr_pkg::ST_NONE;
                break;
              end
              o.evicted++;
            end
            if (o.status == lctr_pkg::ST_INSERT && r.file_len != 0 &&
                r.line_index >= r.file_len)
              o.status = lctr_pkg::ST_OUTSIDE;
            if (o.status == lctr_pkg::ST_INSERT) begin
              for (int i = 0; i < NUM_SLOTS; i++)
                if (!valid_q[i]) begin
                  free_at = i;
                  break;
                end
              if (free_at < 0) begin
                o.status = lctr_pkg::ST_NONE;
              end else begin
                valid_q[free_at] = 1;
                tag_file[free_at] = r.file_id;
                tag_line[free_at] = r.line_index;
                tag_pers[free_at] = r.pers;
                tag_frame[free_at] = frame_now;
                used++;
                o.slot = 11'(free_at);
              end
            end
          end
        end
        lctr_pkg::MODE_FRAME: frame_now = frame_now + 1;
        lctr_pkg::MODE_EVICT: begin
          if (drop_victim()) o.evicted = 1;
          else o.status = lctr_pkg::ST_NONE;
        end
        default: begin
          o.evicted = 12'(used);
          foreach (valid_q[i]) valid_q[i] = 0;
          used = 0;
        end
      endcase
      o.in_use = 12'(used);
      owed.push_back(o);
    endfunction

    function void check_result(logic [39:0] d);
      outcome_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, d);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (d[2:0] !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, d[2:0]);
        errors++;
      end
      if (d[13:3] !== e.slot) begin
        $display("%0t: slot expected %0d actual %0d", $time, e.slot, d[13:3]);
        errors++;
      end
      if (d[25:14] !== e.evicted) begin
        $display("%0t: evicted expected %0d actual %0d", $time, e.evicted, d[25:14]);
        errors++;
      end
      if (d[37:26] !== e.in_use) begin
        $display("%0t: lines in use expected %0d actual %0d", $time, e.in_use, d[37:26]);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [1:0]  in_tuser;   // mode
  logic [87:0] in_tdata;   // file_id, line_index, file_length_lines, persistence
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // status, slot, evicted_count, lines_in_use
  logic        cfg_valid;
  logic        cfg_ready;
  logic [6:0]  cfg_data;   // cache_megabytes

  cache_scoreboard sb;
  bit quiet;         // no idling on either side while set
  bit hold_off_req;  // receiver holds off for a long stretch
  int unsigned idle_cycles;

  line_cache_tag_replacement u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Monitors: everything is sampled at the edge, before the new drives land.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_input('{in_tuser, in_tdata[15:0], in_tdata[46:16], in_tdata[77:47],
                        in_tdata[85:78]});
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if (cfg_valid && cfg_ready) sb.megabytes = cfg_data;
    end
  end

  // Watchdog: counts cycles where no channel moves a word.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random back-pressure, one long hold-off on request.
  initial begin
    out_tready = 0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_tready <= 0;
        repeat (5000) @(posedge clk);
        hold_off_req = 0;
      end else begin
        out_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 36);
        @(posedge clk);
      end
    end
  end

  task automatic send_word(lookup_t r);
    if (!quiet && $urandom_range(99) < 36) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= r.mode;
    in_tdata <= {2'b0, r.pers, r.file_len, r.line_index, r.file_id};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_megabytes(logic [6:0] mb);
    cfg_valid <= 1;
    cfg_data <= mb;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  // Called between phases: the block is idle once every result is back.
  task automatic drain();
    in_tvalid <= 0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic lookup_t req(logic [15:0] f, logic [30:0] l, logic [30:0] n,
                                  logic [7:0] p);
    return '{lctr_pkg::MODE_REQUEST, f, l, n, p};
  endfunction

  // Random word: mostly requests to a small working set so hits and evictions
  // occur; now and then fully random fields to exercise every bit.
  function automatic lookup_t random_word();
    lookup_t r;
    int unsigned pick;
    pick = $urandom_range(99);
    r.mode = (pick < 80) ? lctr_pkg::MODE_REQUEST : (pick < 88) ? lctr_pkg::MODE_FRAME :
             (pick < 96) ? lctr_pkg::MODE_EVICT : lctr_pkg::MODE_CLEAR;
    r.pers = 8'($urandom);
    if ($urandom_range(9) == 0) begin
      r.file_id = 16'($urandom);
      r.line_index = 31'($urandom);
      r.file_len = 31'($urandom);
    end else begin
      r.file_id = 16'($urandom_range(3));
      r.line_index = 31'($urandom_range(23));
      case ($urandom_range(3))
        0: r.file_len = 0;
        1: r.file_len = r.line_index;  // just outside the file
        default: r.file_len = 31'(r.line_index + $urandom_range(1, 40));
      endcase
    end
    return r;
  endfunction

  initial begin
    logic [6:0] phase_mb[5];
    sb = new();
    phase_mb = '{7'd0, 7'd2, 7'd127, 7'd96, 7'd1};
    rst_n <= 0;
    in_tvalid <= 0;
    in_tuser <= lctr_pkg::MODE_REQUEST;
    in_tdata <= '0;
    cfg_valid <= 0;
    cfg_data <= 7'd64;
    quiet = 0;
    hold_off_req = 0;
    idle_cycles = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes, hit paths, outside file, ticks, evict, clear.
    write_megabytes(7'd1);
    send_word(req(16'h0000, 31'd0, 31'd0, 8'd0));
    send_word(req(16'hffff, 31'h7fffffff, 31'd0, 8'hff));
    send_word(req(16'h0000, 31'd0, 31'd0, 8'd5));   // hit raises persistence
    send_word(req(16'h0000, 31'd0, 31'd0, 8'd1));   // hit keeps higher value
    send_word(req(16'h0001, 31'd10, 31'd10, 8'd3)); // line at file end
    send_word(req(16'h0001, 31'd9, 31'd10, 8'd3));
    send_word(req(16'h0002, 31'h7fffffff, 31'h7fffffff, 8'd9));
    send_word('{lctr_pkg::MODE_FRAME, 16'h0, 31'd0, 31'd0, 8'd0});
    send_word(req(16'hffff, 31'h7fffffff, 31'd1, 8'd0)); // hit ignores length
    send_word(req(16'h0003, 31'd4, 31'h7fffffff, 8'd0));
    send_word('{lctr_pkg::MODE_EVICT, 16'h0, 31'd0, 31'd0, 8'd0});
    send_word('{lctr_pkg::MODE_CLEAR, 16'hffff, 31'h7fffffff, 31'h7fffffff, 8'hff});
    send_word('{lctr_pkg::MODE_EVICT, 16'h0, 31'd0, 31'd0, 8'd0}); // empty cache
    send_word('{lctr_pkg::MODE_CLEAR, 16'h0, 31'd0, 31'd0, 8'd0}); // clear when empty
    for (int i = 0; i < 8; i++)
      send_word(req(16'h0005, 31'(i), 31'd0, 8'(i % 3)));
    drain();

    // Random phases, each with its own megabyte setting; 0 and 1 give the same size.
    foreach (phase_mb[k]) begin
      write_megabytes(phase_mb[k]);
      if (k == 1) hold_off_req = 1;
      quiet = (k == 2);
      for (int i = 0; i < 25; i++) send_word(random_word());
      quiet = 0;
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
